/* rtl/sidac_pkg.sv */
// ----------------------------------------------------------------------------
// sidac_pkg: shared definitions for the signed integer to decimal ASCII block
// Widths, ASCII codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
package sidac_pkg;

	// Binary input width and number of decimal digit cells.
	localparam int BIN_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 8;

	// Index into the digit row and the shift counter.
	localparam int IDX_W = $clog2(NUM_DIGITS);
	localparam int CNT_W = $clog2(BIN_W);

	localparam logic [IDX_W-1:0] IDX_LSD  = IDX_W'(0);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BIN_W - 1);

	// ASCII codes used in the text.
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} sidac_state_t;

	// Control shared by every digit cell.
	typedef struct packed {
		logic clr;
		logic shift;
	} sidac_cell_ctrl_t;

endpackage

/* rtl/sidac_in_if.sv */
// ----------------------------------------------------------------------------
// sidac_in_if: input channel
// Carries one signed integer per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sidac_in_if;
	import sidac_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [BIN_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface

/* rtl/sidac_out_if.sv */
// ----------------------------------------------------------------------------
// sidac_out_if: output channel
// Carries one ASCII character per item and a flag on the last character.
// ----------------------------------------------------------------------------
interface sidac_out_if;
	import sidac_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last_char;

	modport source (output valid, output character, output last_char, input ready);
	modport sink   (input valid, input character, input last_char, output ready);

endinterface

/* rtl/sidac_bcd_cell.sv */
// ----------------------------------------------------------------------------
// sidac_bcd_cell: one decimal digit of the shift-and-add-3 converter
// Holds one BCD digit, corrects it when it is five or more and shifts a
// bit in from the lower neighbor and a bit out to the upper neighbor.
// ----------------------------------------------------------------------------
module sidac_bcd_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sidac_pkg::sidac_cell_ctrl_t        ctrl,
	input  logic                               shift_in,
	output logic                               shift_out,
	output logic [sidac_pkg::DIGIT_W-1:0]      digit
);
	import sidac_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// Add three when the digit is five or more, so the shift carries into the
	// next decade.
	always_comb begin
		if (digit_q >= DIGIT_W'(5)) begin
			adj = digit_q + DIGIT_W'(3);
		end else begin
			adj = digit_q;
		end
	end

	assign shift_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	// Digit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clr) begin
			digit_q <= '0;
		end else if (ctrl.shift) begin
			digit_q <= {adj[DIGIT_W-2:0], shift_in};
		end
	end

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// The binary word is shifted bit by bit through the digit cell row (ST_CONV),
// the leading digit is found (ST_FIND), then the text leaves (ST_EMIT) at one
// character per cycle while the output is not stalled, up to 11 characters.
// One item is worked at a time; a new item is taken once the last character
// sits in the output register. Reset clears the controller and output valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	sidac_in_if.sink    num_ch,
	sidac_out_if.source txt_ch
);
	import sidac_pkg::*;

	sidac_state_t      state_q, state_d;
	logic [BIN_W-1:0]  bin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [IDX_W-1:0]  ptr_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic              accept;
	logic              out_free;
	logic [BIN_W-1:0]  raw;
	logic [BIN_W-1:0]  mag;
	logic [IDX_W-1:0]  lead_idx;
	logic [DIGIT_W-1:0] cur_digit;
	sidac_cell_ctrl_t  cell_ctrl;

	logic [DIGIT_W-1:0] digit [NUM_DIGITS];
	logic [NUM_DIGITS:0] carry;

	// Handshake and magnitude of the incoming value.
	assign accept   = num_ch.valid && num_ch.ready;
	assign out_free = !out_valid_q || txt_ch.ready;
	assign raw      = num_ch.value;
	assign mag      = raw[BIN_W-1] ? (~raw + BIN_W'(1)) : raw;

	assign num_ch.ready = (state_q == ST_IDLE);

	// Row of digit cells; the binary word enters at the least significant digit.
	assign cell_ctrl.clr   = accept;
	assign cell_ctrl.shift = (state_q == ST_CONV);
	assign carry[0]        = bin_q[BIN_W-1];

	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
		sidac_bcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.shift_in  (carry[g]),
			.shift_out (carry[g+1]),
			.digit     (digit[g])
		);
	end

	// Most significant nonzero digit; zero gives the units digit.
	always_comb begin
		lead_idx = IDX_LSD;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (digit[i] != '0) begin
				lead_idx = IDX_W'(i);
			end
		end
	end

	assign cur_digit = digit[ptr_q];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && !neg_q && ptr_q == IDX_LSD) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_CONV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Work registers: binary shifter, sign and digit pointer.
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= mag;
			neg_q <= raw[BIN_W-1];
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end else if (state_q == ST_FIND) begin
			ptr_q <= lead_idx;
		end else if (state_q == ST_EMIT && out_free) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else if (ptr_q != IDX_LSD) begin
				ptr_q <= ptr_q - IDX_W'(1);
			end
		end
	end

	// Output register: valid under reset, payload loaded when a character goes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			if (neg_q) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= ASCII_ZERO + CHAR_W'(cur_digit);
				last_q <= (ptr_q == IDX_LSD);
			end
		end
	end

	assign txt_ch.valid     = out_valid_q;
	assign txt_ch.character = char_q;
	assign txt_ch.last_char = last_q;

	// Every character shown is a minus sign or a decimal digit.
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (char_q == ASCII_MINUS) ||
			(char_q >= ASCII_ZERO && char_q <= ASCII_NINE))
		else $error("output character is neither a digit nor a minus sign");

	// A minus sign is never the end of a run.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_q == ASCII_MINUS) |-> !last_q)
		else $error("minus sign flagged as last character");

	// An accepted item starts the shift phase with a cleared counter.
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && (cnt_q == '0))
		else $error("accepted item did not start conversion");

	// The search for the leading digit follows exactly the last shift.
	a_find_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND) |-> ($past(state_q) == ST_CONV) &&
			($past(cnt_q) == CNT_LAST))
		else $error("leading digit search entered before all shifts");

endmodule

/* bench/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii: self-checking bench for the decimal printer
// Sends signed 32-bit integers: directed corners, random values of every digit
// count under several idle and stall patterns, and a long output hold-off.
// Each item's expected text is worked out on acceptance and every character
// leaving the block is checked in order against it.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
	import sidac_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 4;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLDOFF_LEN  = 300;

	// One character of expected text.
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last_char;
	} ascii_char_t;

	logic clk;
	logic arst_n;

	sidac_in_if  num_if ();
	sidac_out_if txt_if ();

	signed_int_to_decimal_ascii u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num_ch (num_if),
		.txt_ch (txt_if)
	);

	ascii_char_t pending_chars [$];
	int          mismatch_count;
	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          holdoff_len;
	int          cycle_count;

	// Clock.
	always #HALF_PERIOD clk = ~clk;

	// Append the decimal text of one integer to the expected characters.
	function automatic void queue_decimal_text(input logic signed [BIN_W-1:0] number);
		logic [BIN_W-1:0]   magnitude;
		logic [DIGIT_W-1:0] digit_row [NUM_DIGITS];
		int                 n_digits;
		ascii_char_t        entry;
		magnitude = number;
		if (number[BIN_W-1]) begin
			magnitude = ~magnitude + 1;
		end
		n_digits = 0;
		do begin
			digit_row[n_digits] = DIGIT_W'(magnitude % 10);
			magnitude = magnitude / 10;
			n_digits++;
		end while (magnitude != 0 && n_digits < NUM_DIGITS);
		if (number[BIN_W-1]) begin
			entry.character = ASCII_MINUS;
			entry.last_char = 1'b0;
			pending_chars.push_back(entry);
		end
		for (int i = n_digits - 1; i >= 0; i--) begin
			entry.character = ASCII_ZERO + CHAR_W'(digit_row[i]);
			entry.last_char = (i == 0);
			pending_chars.push_back(entry);
		end
	endfunction

	// Offer one integer, after a random idle stretch, and wait until it is taken.
	task automatic send_value(input logic signed [BIN_W-1:0] number);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			num_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		num_if.valid <= 1'b1;
		num_if.value <= number;
		do @(posedge clk); while (!num_if.ready);
		queue_decimal_text(number);
	endtask

	// Output side: random stalls, or a held-off stretch when one is requested.
	always @(posedge clk) begin
		if (arst_n) begin
			if (holdoff_len != 0) begin
				txt_if.ready <= 1'b0;
				holdoff_len  <= holdoff_len - 1;
			end else begin
				txt_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Compare every character taken from the block with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && txt_if.valid && txt_if.ready) begin
			if (pending_chars.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected character: got char=%h last=%b",
					$time, txt_if.character, txt_if.last_char);
			end else begin
				if (txt_if.character !== pending_chars[0].character) begin
					mismatch_count++;
					$display("%0t: character mismatch: expected %h, got %h",
						$time, pending_chars[0].character, txt_if.character);
				end
				if (txt_if.last_char !== pending_chars[0].last_char) begin
					mismatch_count++;
					$display("%0t: last_char mismatch: expected %b, got %b",
						$time, pending_chars[0].last_char, txt_if.last_char);
				end
				void'(pending_chars.pop_front());
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_signed_int_to_decimal_ascii: errors");
			$finish;
		end
	end

	// Corners: zero, single digits, digit-count boundaries and both extremes.
	task automatic test_corner_values();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		send_value(32'sd0);
		send_value(32'sd1);
		send_value(-32'sd1);
		send_value(32'sd9);
		send_value(32'sd10);
		send_value(-32'sd10);
		send_value(32'sd99);
		send_value(32'sd100);
		send_value(32'sd999999999);
		send_value(32'sd1000000000);
		send_value(-32'sd999999999);
		send_value(-32'sd1000000000);
		send_value(32'sd1234567890);
		send_value(32'sh7FFFFFFF);
		send_value(32'sh80000000);
		send_value(32'sh80000001);
		send_value(32'sh55555555);
		send_value(32'shAAAAAAAA);
	endtask

	// Random values; most have a random digit count so short texts are common.
	task automatic test_random_values(input int n_items, input int idle_pct,
			input int stall_pct);
		int                      n_dig;
		longint                  lo;
		longint                  hi;
		longint                  mag;
		logic signed [BIN_W-1:0] number;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(3) == 0) begin
				number = $urandom;
			end else begin
				n_dig = $urandom_range(NUM_DIGITS, 1);
				lo    = (n_dig == 1) ? 0 : 10 ** (n_dig - 1);
				hi    = (n_dig == NUM_DIGITS) ? 64'h7FFFFFFF : 10 ** n_dig - 1;
				mag   = lo + longint'($urandom_range(32'(hi - lo)));
				number = BIN_W'(mag);
				if ($urandom_range(1) == 1) begin
					number = -number;
				end
			end
			send_value(number);
		end
	endtask

	// Hold the output off for a long stretch while items keep coming.
	task automatic test_output_holdoff();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		holdoff_len       <= HOLDOFF_LEN;
		for (int i = 0; i < 12; i++) begin
			send_value(32'($urandom));
		end
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		num_if.valid       = 1'b0;
		num_if.value       = '0;
		txt_if.ready       = 1'b0;
		mismatch_count     = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		holdoff_len        = 0;
		cycle_count        = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_random_values(38, 0, 0);
		test_random_values(38, 84, 0);
		test_random_values(38, 0, 84);
		test_random_values(38, 24, 24);
		test_output_holdoff();

		// Drain the text still in flight, then allow for stray output.
		num_if.valid <= 1'b0;
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_signed_int_to_decimal_ascii: clean");
		end else begin
			$display("tb_signed_int_to_decimal_ascii: errors");
		end
		$finish;
	end

endmodule
